// ===== hdl/sha_pkg.sv =====
// Shared constants, types and round functions for the SHA-256 digest block.
package sha_pkg;

  localparam int unsigned CountWidth = 61;

  typedef logic [31:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put_byte;   // write the input byte at the current position
    logic       put_pad;    // write 0x80 at the current position
    logic       clr_tail;   // zero the bytes after the current position
    logic       clr_all;    // zero the whole block buffer
    logic       put_len;    // write the bit length into words 14 and 15
    logic       cnt_inc;    // advance the byte count
    logic       cnt_clr;    // clear the byte count
    logic       comp_load;  // copy buffer and hash into the round registers
    logic       round;      // perform one round
    logic       comp_fold;  // add the working variables into the hash
    logic       hash_init;  // reload the initial hash
    logic [5:0] rnd;        // round number
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] pos;        // byte position in the block
  } sha_stat_t;

  function automatic word_t k_const(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t h_init(input logic [2:0] i);
    word_t h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hdl/sha256_message_digest.sv =====
// Top level of the SHA-256 digest block: controller and datapath.
// Usage:
//   Input channel (in_valid/in_stall) carries one byte per beat with
//   byte_present and message_end. A beat with byte_present 0 and
//   message_end 1 closes an empty message; with both 0 it does nothing.
//   Output channel (out_valid/out_stall) carries the eight digest words,
//   word_index 0 first, last_word set on word 7.
// Sequence:
//   An ordinary byte is taken while the sequencer idles. The beat that fills a
//   64-byte block holds the input through one load, 64 rounds of the single
//   round unit and one fold. Message end adds padding (pad byte and length,
//   with a zeroed block when the length needs a second block) and one or two
//   compressions, then eight output beats and a hash reload.
// Reset:
//   rst clears the byte count, loads the initial hash and idles the
//   sequencer. While out_stall is high the current digest word holds and no
//   input beat is taken until all eight words have left.
module sha256_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic      in_ready;
  logic [2:0] out_index;

  sha_control u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall_unused_n (1'b1),
    .byte_present      (byte_present),
    .message_end       (message_end),
    .out_stall         (out_stall),
    .stat              (stat),
    .cmd               (cmd),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_index         (out_index)
  );

  sha_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (data_byte),
    .rd_index  (out_index),
    .stat      (stat),
    .rd_word   (digest_word)
  );

  assign in_stall   = !in_ready;
  assign word_index = out_index;
  assign last_word  = (out_index == 3'd7);

`ifndef ASSERT_OFF
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during digest output");
  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(word_index))
    else $error("digest word moved while stalled");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_word && !out_stall |=> !out_valid)
    else $error("output continued past last word");
`endif

endmodule

// ===== hdl/sha_datapath.sv =====
// Block buffer, byte count, message schedule, round logic and hash registers.
module sha_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [7:0]        data_byte,
  input  logic [2:0]        rd_index,
  output sha_pkg::sha_stat_t stat,
  output sha_pkg::word_t    rd_word
);
  import sha_pkg::*;

  word_t                 blk [16];
  word_t                 win [16];
  word_t                 wv  [8];
  word_t                 hs  [8];
  logic [CountWidth-1:0] count;

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [63:0] bits;
  word_t       w, w2, w7, w15, w16, o0, o1, s0, s1, ch, mj, t1, t2;

  assign pos       = count[5:0];
  assign stat.pos  = pos;
  assign bits      = {count, 3'b000};
  assign rd_word   = hs[rd_index];
  assign wi        = cmd.rnd[3:0];

  always_comb begin
    w2  = win[wi - 4'd2];
    w7  = win[wi - 4'd7];
    w15 = win[wi - 4'd15];
    w16 = win[wi];
    o1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    o0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    w   = (cmd.rnd[5:4] == 2'd0) ? w16 : (o1 + w7 + o0 + w16);
    s1  = rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25);
    ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    t1  = wv[7] + s1 + ch + k_const(cmd.rnd) + w;
    s0  = rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22);
    mj  = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t2  = s0 + mj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.hash_init) begin
      for (int i = 0; i < 8; i++) hs[i] <= h_init(3'(i));
    end else if (cmd.comp_fold) begin
      for (int i = 0; i < 8; i++) hs[i] <= hs[i] + wv[i];
    end
  end

  // Block buffer writes; byte lanes are big-endian within each word.
  always_ff @(posedge clk) begin
    if (cmd.clr_all) begin
      for (int i = 0; i < 16; i++) blk[i] <= '0;
    end else begin
      for (int b = 0; b < 64; b++) begin
        if ((cmd.put_byte || cmd.put_pad) && pos == 6'(b)) begin
          blk[b/4][(3-b%4)*8 +: 8] <= cmd.put_pad ? 8'h80 : data_byte;
        end else if (cmd.clr_tail && 6'(b) > pos) begin
          blk[b/4][(3-b%4)*8 +: 8] <= 8'h00;
        end
      end
      if (cmd.put_len) begin
        blk[14] <= bits[63:32];
        blk[15] <= bits[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_load) begin
      for (int i = 0; i < 16; i++) win[i] <= blk[i];
      for (int i = 0; i < 8; i++) wv[i] <= hs[i];
    end else if (cmd.round) begin
      win[wi] <= w;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

endmodule

// ===== hdl/sha_control.sv =====
// Sequencer for byte intake, padding, compression rounds and digest output.
module sha_control (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall_unused_n,
  input  logic               byte_present,
  input  logic               message_end,
  input  logic               out_stall,
  input  sha_pkg::sha_stat_t stat,
  output sha_pkg::sha_cmd_t  cmd,
  output logic               in_ready,
  output logic               out_valid,
  output logic [2:0]         out_index
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_PAD2, ST_LEN, ST_OUT, ST_INIT
  } state_t;

  state_t     state;
  logic [5:0] rnd;
  logic       end_pend;   // message closes after the current compression
  logic       tail_pend;  // an all-zero length block follows the current compression
  logic       pad_done;   // padding placed; next compression is the final one
  logic       take;

  assign in_ready = (state == ST_IDLE) && in_stall_unused_n;
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.rnd       = rnd;
    cmd.put_byte  = take && byte_present;
    cmd.cnt_inc   = take && byte_present;
    cmd.comp_load = (state == ST_LOAD);
    cmd.round     = (state == ST_ROUND);
    cmd.comp_fold = (state == ST_FOLD);
    cmd.put_pad   = (state == ST_PAD);
    cmd.clr_tail  = (state == ST_PAD);
    cmd.clr_all   = (state == ST_PAD2);
    cmd.put_len   = (state == ST_LEN);
    cmd.hash_init = (state == ST_INIT);
    cmd.cnt_clr   = (state == ST_INIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      end_pend  <= 1'b0;
      tail_pend <= 1'b0;
      pad_done  <= 1'b0;
      out_valid <= 1'b0;
      out_index <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            end_pend <= message_end;
            if (byte_present && stat.pos == 6'd63) state <= ST_LOAD;
            else if (message_end) state <= ST_PAD;
          end
        end
        ST_LOAD: begin
          rnd   <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= ST_FOLD;
        end
        ST_FOLD: begin
          if (pad_done) begin
            pad_done  <= 1'b0;
            out_valid <= 1'b1;
            out_index <= '0;
            state     <= ST_OUT;
          end else if (tail_pend) begin
            tail_pend <= 1'b0;
            state     <= ST_PAD2;
          end else if (end_pend) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PAD: begin
          end_pend <= 1'b0;
          // Length does not fit after the pad byte: compress, then an all-zero block.
          if (stat.pos >= 6'd56) begin
            tail_pend <= 1'b1;
            state     <= ST_LOAD;
          end else begin
            state <= ST_LEN;
          end
        end
        ST_PAD2: state <= ST_LEN;
        ST_LEN: begin
          pad_done <= 1'b1;
          state    <= ST_LOAD;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_index <= out_index + 3'd1;
            if (out_index == 3'd7) begin
              out_valid <= 1'b0;
              state     <= ST_INIT;
            end
          end
        end
        ST_INIT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_sha256_message_digest.sv =====
// Testbench for the SHA-256 digest block: directed and random messages checked against a local digest model.
module tb_sha256_message_digest;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        byte_present = 1'b0;
  logic        message_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       fin;
  } byte_beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  localparam int unsigned WatchLimit = 20000;

  byte_beat_t   pending_beats[$];
  digest_beat_t expected_words[$];

  logic [31:0] hash_h[8];
  logic [31:0] blk[16];
  logic [60:0] msg_bytes;

  int  fail_cnt = 0;
  int  idle_cnt = 0;
  int  in_gap = 0;
  int  out_gap = 0;

  sha256_message_digest DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_const(input int t);
    logic [31:0] k[64];
    k = '{32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
          32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
          32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
          32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
          32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
          32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
          32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
          32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
          32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
          32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
          32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[t];
  endfunction

  task automatic load_iv();
    hash_h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
               32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
  endtask

  task automatic compress_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int t = 16; t < 64; t++)
      w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    v = hash_h;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(t) + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic place_byte(input int p, input logic [7:0] b);
    blk[p/4][(3 - p%4)*8 +: 8] = b;
  endtask

  // Advance the digest model by one accepted beat.
  task automatic digest_absorb(input byte_beat_t bt);
    int p;
    logic [63:0] bits;
    if (bt.present) begin
      p = msg_bytes[5:0];
      place_byte(p, bt.data);
      msg_bytes = msg_bytes + 1;
      if (p == 63) compress_block();
    end
    if (bt.fin) begin
      p = msg_bytes[5:0];
      place_byte(p, 8'h80);
      for (int i = p + 1; i < 64; i++) place_byte(i, 8'h00);
      if (p >= 56) begin
        compress_block();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      bits = {msg_bytes, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress_block();
      for (int i = 0; i < 8; i++) expected_words.push_back({hash_h[i], 3'(i), i == 7});
      load_iv();
      msg_bytes = '0;
    end
  endtask

  task automatic queue_message(input int len, input int pattern);
    byte_beat_t bt;
    for (int i = 0; i < len; i++) begin
      // Sprinkle bare beats that the block must ignore.
      if ($urandom_range(0, 15) == 0) pending_beats.push_back({8'h00, 1'b0, 1'b0});
      case (pattern)
        0: bt.data = 8'h00;
        1: bt.data = 8'hff;
        default: bt.data = 8'($urandom);
      endcase
      bt.present = 1'b1;
      bt.fin = (i == len - 1) && ($urandom_range(0, 1) == 1);
      pending_beats.push_back(bt);
      if (bt.fin) return;
    end
    pending_beats.push_back({8'($urandom), 1'b0, 1'b1});
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  initial begin
    for (int i = 0; i < 16; i++) blk[i] = '0;
    load_iv();
    msg_bytes = '0;
    // Directed: empty message, bare beat, single bytes, padding boundaries.
    pending_beats.push_back({8'h00, 1'b0, 1'b0});
    pending_beats.push_back({8'hff, 1'b0, 1'b1});
    pending_beats.push_back({8'h61, 1'b1, 1'b1});
    pending_beats.push_back({8'hff, 1'b1, 1'b0});
    pending_beats.push_back({8'h00, 1'b0, 1'b1});
    queue_message(55, 0);
    queue_message(56, 1);
    queue_message(64, 2);
    // Random messages fill the rest of the beat budget.
    while (pending_beats.size() < 225) begin
      int len;
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 130) : $urandom_range(1, 12);
      if (len > 228 - int'(pending_beats.size())) len = 228 - int'(pending_beats.size());
      queue_message(len, 2);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Input driver.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        digest_absorb(pending_beats.pop_front());
        in_gap = pick_gap();
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0 || pending_beats.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid     <= 1'b1;
          data_byte    <= pending_beats[0].data;
          byte_present <= pending_beats[0].present;
          message_end  <= pending_beats[0].fin;
        end
      end
    end
  end

  // Output monitor and stall generator.
  always @(posedge clk) begin
    digest_beat_t exp_w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("digest word with nothing expected: %h", digest_word);
          fail_cnt++;
        end else begin
          exp_w = expected_words.pop_front();
          if (digest_word !== exp_w.word) begin
            $error("digest_word expected %h actual %h", exp_w.word, digest_word);
            fail_cnt++;
          end
          if (word_index !== exp_w.idx) begin
            $error("word_index expected %0d actual %0d", exp_w.idx, word_index);
            fail_cnt++;
          end
          if (last_word !== exp_w.last) begin
            $error("last_word expected %0b actual %0b", exp_w.last, last_word);
            fail_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
      else idle_cnt++;
      if (pending_beats.size() == 0 && !in_valid && expected_words.size() == 0
          && idle_cnt > 300) begin
        if (fail_cnt == 0) $display("sha256_message_digest verification clean");
        else $display("sha256_message_digest verification failed");
        $finish;
      end else if (idle_cnt >= WatchLimit) begin
        $display("sha256_message_digest verification failed");
        $finish;
      end
    end
  end

endmodule
